>>> rtl/core/alb_pkg.sv
`default_nettype none

package alb_pkg;

    localparam int unsigned MAX_ALERTS  = 16;
    localparam int unsigned MAX_GROUPS  = 16;
    localparam int unsigned COUNT_W     = 8;
    localparam int unsigned GROUP_NUM_W = 4;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 64;

    // Item actions
    typedef enum logic [1:0] {
        ACT_SET       = 2'd0,
        ACT_CLEAR     = 2'd1,
        ACT_RESET_ALL = 2'd2
    } action_t;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_LOW  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_HIGH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LATCH_MASK  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLEAR_MASK  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_GROUP_MAP   = 3'd4;

    typedef struct packed {
        logic [63:0]           period_low;
        logic [63:0]           period_high;
        logic [MAX_ALERTS-1:0] latch_mask;
        logic [MAX_ALERTS-1:0] clear_mask;
        logic [63:0]           group_map;
    } cfg_t;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] alert_index;
        logic       condition;
    } item_t;

endpackage

`default_nettype wire

>>> rtl/core/alb_chan_bank.sv
`default_nettype none

module alb_chan_bank #(
    parameter int unsigned NUM_ALERTS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          update,
    input  wire alb_pkg::item_t                item,
    input  wire alb_pkg::cfg_t                 cfg,
    output logic [alb_pkg::MAX_ALERTS-1:0]     alert_next
);
    import alb_pkg::*;

    logic set_any;
    logic clear_one;
    logic clear_all;

    // Decode the action once for every channel
    always_comb begin
        set_any   = 1'b0;
        clear_one = 1'b0;
        clear_all = 1'b0;
        case (item.action)
            ACT_SET:       set_any   = 1'b1;
            ACT_CLEAR:     clear_one = 1'b1;
            ACT_RESET_ALL: clear_all = 1'b1;
            default:       ;
        endcase
    end

    genvar i;
    generate
        for (i = 0; i < MAX_ALERTS; i++) begin : g_chan
            if (i < NUM_ALERTS) begin : g_live
                logic [COUNT_W-1:0] count_reg;
                logic [COUNT_W-1:0] count_next;
                logic               seen_reg;
                logic               seen_next;
                logic               out_reg;
                logic               out_next;
                logic [COUNT_W-1:0] period;
                logic [COUNT_W-1:0] count_set;
                logic               hit;
                logic               may_clear;

                if (i < 8) begin : g_lo
                    assign period = cfg.period_low[(i % 8) * 8 +: 8];
                end else begin : g_hi
                    assign period = cfg.period_high[(i % 8) * 8 +: 8];
                end

                assign hit       = (item.alert_index == 4'(i));
                assign may_clear = !cfg.latch_mask[i] || cfg.clear_mask[i];

                // Advance or clear debounce count, settle output
                always_comb begin
                    count_next = count_reg;
                    seen_next  = seen_reg;
                    out_next   = out_reg;
                    count_set  = '0;
                    if (update) begin
                        if (set_any && hit) begin
                            if (seen_reg == item.condition) begin
                                count_set = (count_reg < period)
                                    ? COUNT_W'(count_reg + 1'b1) : count_reg;
                            end
                            count_next = count_set;
                            seen_next  = item.condition;
                            if (count_set >= period) begin
                                if (item.condition) begin
                                    out_next = 1'b1;
                                end else if (!cfg.latch_mask[i]) begin
                                    out_next = 1'b0;
                                end
                            end
                        end else if (((clear_one && hit) || clear_all) && may_clear) begin
                            count_next = '0;
                            seen_next  = 1'b0;
                            out_next   = 1'b0;
                        end
                    end
                end

                always_ff @(posedge aclk) begin
                    if (!aresetn) begin
                        count_reg <= '0;
                        seen_reg  <= 1'b0;
                        out_reg   <= 1'b0;
                    end else begin
                        count_reg <= count_next;
                        seen_reg  <= seen_next;
                        out_reg   <= out_next;
                    end
                end

                assign alert_next[i] = out_next;
            end else begin : g_absent
                assign alert_next[i] = 1'b0;
            end
        end
    endgenerate

endmodule

`default_nettype wire

>>> rtl/core/alb_group_sum.sv
`default_nettype none

module alb_group_sum #(
    parameter int unsigned NUM_GROUPS = 16
) (
    input  wire logic [alb_pkg::MAX_ALERTS-1:0] alert_flags,
    input  wire logic [63:0]                    group_map,
    output logic [alb_pkg::MAX_GROUPS-1:0]      group_flags
);
    import alb_pkg::*;

    localparam logic [GROUP_NUM_W:0] GROUP_LIMIT = (GROUP_NUM_W + 1)'(NUM_GROUPS);

    logic [GROUP_NUM_W-1:0] grp;

    // OR raised alerts into valid groups, and always into the any-alert bit
    always_comb begin
        group_flags = '0;
        grp         = '0;
        for (int a = 0; a < MAX_ALERTS; a++) begin
            grp = group_map[a * GROUP_NUM_W +: GROUP_NUM_W];
            if (alert_flags[a]) begin
                group_flags[0] = 1'b1;
                if ({1'b0, grp} < GROUP_LIMIT) begin
                    group_flags[grp] = 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/debounced_latching_alert_bank.sv
`default_nettype none

// Bank of debounced alert channels with per-group summary flags.
//
// Input channel (s_*): one transaction per event: set a channel's raw
// condition, clear one channel, or clear every clearable channel.
// Result channel (m_*): one transaction per input transaction, in order,
// carrying every alert output bit and the group OR flags after that event.
// Configuration channel (cfg_*): always ready; write only while the bank
// is idle.
//
// Flow: the input register takes the transaction, then the result register
// loads it once that register is free, which raises m_valid. Throughput: one
// transaction per cycle while m_ready stays high, set by the combinational
// channel update and group OR tree.
// Reset (aresetn low, synchronous): all counters, seen bits, outputs and
// configuration registers go to zero, and both stages empty.
// A stalled receiver holds the result register; the input register keeps
// one more transaction, after which s_ready drops until m_ready returns.
module debounced_latching_alert_bank #(
    parameter int unsigned NUM_ALERTS = 16,
    parameter int unsigned NUM_GROUPS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [3:0]  s_alert_index,
    input  wire logic        s_condition,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_alert_flags,
    output logic [15:0]      m_group_flags,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [alb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [alb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import alb_pkg::*;

    cfg_t  cfg_reg;
    item_t item_reg;
    logic  item_valid_reg;
    logic  out_valid_reg;
    logic  advance;

    logic [MAX_ALERTS-1:0] alert_next;
    logic [MAX_GROUPS-1:0] group_next;
    logic [15:0]           alert_flags_reg;
    logic [15:0]           group_flags_reg;

    assign cfg_ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_PERIOD_LOW:  cfg_reg.period_low  <= cfg_data;
                CFG_PERIOD_HIGH: cfg_reg.period_high <= cfg_data;
                CFG_LATCH_MASK:  cfg_reg.latch_mask  <= cfg_data[MAX_ALERTS-1:0];
                CFG_CLEAR_MASK:  cfg_reg.clear_mask  <= cfg_data[MAX_ALERTS-1:0];
                CFG_GROUP_MAP:   cfg_reg.group_map   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Move the held transaction into the result register when it is free
    assign advance = item_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !item_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_ready) begin
            item_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.action      <= s_action;
            item_reg.alert_index <= s_alert_index;
            item_reg.condition   <= s_condition;
        end
    end

    alb_chan_bank #(
        .NUM_ALERTS (NUM_ALERTS)
    ) u_chan_bank (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .update     (advance),
        .item       (item_reg),
        .cfg        (cfg_reg),
        .alert_next (alert_next)
    );

    alb_group_sum #(
        .NUM_GROUPS (NUM_GROUPS)
    ) u_group_sum (
        .alert_flags (alert_next),
        .group_map   (cfg_reg.group_map),
        .group_flags (group_next)
    );

    // Hold the result until the receiver takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            alert_flags_reg <= alert_next;
            group_flags_reg <= group_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_alert_flags = alert_flags_reg;
    assign m_group_flags = group_flags_reg;

endmodule

`default_nettype wire
